>>> src/vtpa_pkg.sv
// Package for the vertex track pair angle block: item types, register
// indexes, state encodings and the CORDIC angle table. No dependencies.
package vtpa_pkg;

  typedef struct packed {
    logic               has_track;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic [47:0]        start_direction;
    logic [47:0]        end_direction;
    logic [15:0]        track_length;
    logic               last_track;
  } vtpa_in_t;

  typedef struct packed {
    logic [14:0] angle;
    logic        angle_valid;
    logic [1:0]  kept_count;
  } vtpa_out_t;

  // classified track handed from front to back
  typedef struct packed {
    logic        keep;
    logic [15:0] len;
    logic [47:0] dir;
    logic        last;
  } vtpa_rec_t;

  typedef struct packed {
    logic [11:0]        max_distance;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
  } vtpa_cfg_t;

  localparam logic [1:0] CFG_MAX_DISTANCE = 2'd0;
  localparam logic [1:0] CFG_VERTEX_X     = 2'd1;
  localparam logic [1:0] CFG_VERTEX_Y     = 2'd2;
  localparam logic [1:0] CFG_VERTEX_Z     = 2'd3;

  localparam logic [11:0] MAX_DISTANCE_RST = 12'd160;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [19:0] PI_Q13 = 20'd25736;
  localparam int unsigned CORDIC_STEPS = 16;

  typedef enum logic [1:0] {F_IDLE, F_DIFF, F_SQ, F_PUSH} vtpa_front_e;

  typedef enum logic [2:0] {
    B_IDLE, B_DOT, B_SUM, B_SQ, B_SUB, B_SQRT, B_CORDIC, B_DONE
  } vtpa_back_e;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    logic signed [19:0] a;
    unique case (i)
      4'd0:  a = 20'sd51472;
      4'd1:  a = 20'sd30385;
      4'd2:  a = 20'sd16055;
      4'd3:  a = 20'sd8150;
      4'd4:  a = 20'sd4091;
      4'd5:  a = 20'sd2047;
      4'd6:  a = 20'sd1024;
      4'd7:  a = 20'sd512;
      4'd8:  a = 20'sd256;
      4'd9:  a = 20'sd128;
      4'd10: a = 20'sd64;
      4'd11: a = 20'sd32;
      4'd12: a = 20'sd16;
      4'd13: a = 20'sd8;
      4'd14: a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

  // negate each Q1.14 component, -32768 saturates to +32767
  function automatic logic [47:0] neg_dir(input logic [47:0] d);
    logic [47:0] r;
    for (int k = 0; k < 3; k++) begin
      if (d[16*k +: 16] == 16'h8000) r[16*k +: 16] = 16'h7fff;
      else r[16*k +: 16] = 16'(-d[16*k +: 16]);
    end
    return r;
  endfunction

endpackage

>>> src/vertex_track_pair_angle.sv
// Top level of the vertex track pair angle block: configuration registers,
// front, queue and back. Depends on vtpa_pkg, vtpa_front, vtpa_fifo, vtpa_back.
//
// Usage:
//   Tracks of one event enter through push/full, one item per track; an item
//   with has_track low carries no track. The item with last_track high closes
//   the event and yields one result on empty/pop: angle (Q2.13 rad), the
//   valid flag (two or more kept tracks) and the kept count.
//   The front works through capture, difference, squares and queue write for
//   each item; after an item is taken, full stays high until its queue write
//   is done. A two-entry queue hands classified tracks to the back, which
//   absorbs one per cycle while idle and not held by a waiting result.
//   An event with two kept tracks then runs, in order: dot product and clamp,
//   square and subtract, a 29-step bit-serial square root, a 16-step CORDIC,
//   and a final step to round and store.
//   Other events store their result as the closing item is taken.
//   Results wait in one output register; while it is held (pop low) the
//   block keeps taking tracks and stalls only on the next closing item.
//   Reset clears event state and the queue; max_distance resets to 160,
//   the vertex to the origin. Write configuration only while idle.
module vertex_track_pair_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  vtpa_pkg::vtpa_in_t  in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output vtpa_pkg::vtpa_out_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import vtpa_pkg::*;

  vtpa_cfg_t cfg_q;
  vtpa_rec_t rec_w, rec_r;
  logic      q_wr, q_full, q_rd, q_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_distance <= MAX_DISTANCE_RST;
      cfg_q.vertex_x     <= '0;
      cfg_q.vertex_y     <= '0;
      cfg_q.vertex_z     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_DISTANCE: cfg_q.max_distance <= cfg_data_i[11:0];
        CFG_VERTEX_X:     cfg_q.vertex_x     <= cfg_data_i;
        CFG_VERTEX_Y:     cfg_q.vertex_y     <= cfg_data_i;
        CFG_VERTEX_Z:     cfg_q.vertex_z     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vtpa_front u_front (
    .clk_i, .rst_ni,
    .cfg_i   (cfg_q),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .wr_o    (q_wr),
    .rec_o   (rec_w),
    .q_full_i(q_full)
  );

  vtpa_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_i   (q_wr),
    .wdata_i(rec_w),
    .full_o (q_full),
    .rd_i   (q_rd),
    .rdata_o(rec_r),
    .empty_o(q_empty)
  );

  vtpa_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty),
    .rec_i    (rec_r),
    .rd_o     (q_rd),
    .empty_o  (empty),
    .pop_i    (pop),
    .out_o    (out_item_o)
  );

  // a valid angle always comes from two kept tracks
  a_valid_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.angle_valid == (out_item_o.kept_count == 2'd2)))
    else $error("angle_valid disagrees with kept_count");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(out_item_o.angle) <= 32'd25736))
    else $error("angle above pi");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.angle_valid) |-> (out_item_o.angle == 15'd0))
    else $error("invalid result with nonzero angle");

endmodule

>>> src/vtpa_fifo.sv
// Two-entry queue between front and back of the vertex track pair angle block.
// Depends on vtpa_pkg.
module vtpa_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  vtpa_pkg::vtpa_rec_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output vtpa_pkg::vtpa_rec_t rdata_o,
  output logic              empty_o
);
  import vtpa_pkg::*;

  vtpa_rec_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i && !full_o) wptr_q <= ~wptr_q;
      if (rd_i && !empty_o) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'((wr_i && !full_o) ? 1 : 0) - 2'((rd_i && !empty_o) ? 1 : 0);
    end
  end
endmodule

>>> src/vtpa_front.sv
// Front of the vertex track pair angle block: accepts a track, runs the
// squared distance tests and picks the direction. Depends on vtpa_pkg.
module vtpa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vtpa_pkg::vtpa_cfg_t cfg_i,
  input  logic                push_i,
  input  vtpa_pkg::vtpa_in_t  item_i,
  output logic                full_o,
  output logic                wr_o,
  output vtpa_pkg::vtpa_rec_t rec_o,
  input  logic                q_full_i
);
  import vtpa_pkg::*;

  vtpa_front_e state_q, state_d;
  vtpa_in_t    item_q;
  logic signed [16:0] dsx_q, dsy_q, dsz_q, dex_q, dey_q, dez_q;
  logic [32:0] qsx_q, qsy_q, qsz_q, qex_q, qey_q, qez_q;
  logic [23:0] md2_q;
  logic [34:0] sum_s, sum_e;
  logic        near_s, near_e;

  function automatic logic signed [16:0] dif(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
    return 17'({a[15], a}) - 17'({b[15], b});
  endfunction

  function automatic logic [32:0] sq(input logic signed [16:0] d);
    logic signed [33:0] p;
    p = d * d;
    return p[32:0];
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (push_i) state_d = F_DIFF;
      F_DIFF:  state_d = F_SQ;
      F_SQ:    state_d = F_PUSH;
      F_PUSH:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o = state_q != F_IDLE;
    wr_o   = (state_q == F_PUSH) && !q_full_i;
  end

  assign sum_s  = 35'(qsx_q) + 35'(qsy_q) + 35'(qsz_q);
  assign sum_e  = 35'(qex_q) + 35'(qey_q) + 35'(qez_q);
  assign near_s = sum_s < 35'(md2_q);
  assign near_e = sum_e < 35'(md2_q);

  always_comb begin
    rec_o.keep = item_q.has_track && (near_s || near_e);
    rec_o.len  = item_q.track_length;
    rec_o.dir  = near_s ? item_q.start_direction : neg_dir(item_q.end_direction);
    rec_o.last = item_q.last_track;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) item_q <= item_i;
    if (state_q == F_DIFF) begin
      dsx_q <= dif(item_q.start_x, cfg_i.vertex_x);
      dsy_q <= dif(item_q.start_y, cfg_i.vertex_y);
      dsz_q <= dif(item_q.start_z, cfg_i.vertex_z);
      dex_q <= dif(item_q.end_x, cfg_i.vertex_x);
      dey_q <= dif(item_q.end_y, cfg_i.vertex_y);
      dez_q <= dif(item_q.end_z, cfg_i.vertex_z);
    end
    if (state_q == F_SQ) begin
      qsx_q <= sq(dsx_q);
      qsy_q <= sq(dsy_q);
      qsz_q <= sq(dsz_q);
      qex_q <= sq(dex_q);
      qey_q <= sq(dey_q);
      qez_q <= sq(dez_q);
      md2_q <= cfg_i.max_distance * cfg_i.max_distance;
    end
  end
endmodule

>>> src/vtpa_back.sv
// Back of the vertex track pair angle block: keeps the two longest tracks
// and runs the arccos unit (dot, isqrt, CORDIC). Depends on vtpa_pkg.
module vtpa_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  vtpa_pkg::vtpa_rec_t rec_i,
  output logic                rd_o,
  output logic                empty_o,
  input  logic                pop_i,
  output vtpa_pkg::vtpa_out_t out_o
);
  import vtpa_pkg::*;

  vtpa_back_e state_q, state_d;
  logic [15:0] l1_q, l2_q, l1_d, l2_d;
  logic [47:0] d1_q, d2_q, d1_d, d2_d;
  logic [1:0]  kept_q, kept_d;
  logic        out_vld_q;
  vtpa_out_t   out_q;
  logic signed [31:0] p0_q, p1_q, p2_q;
  logic signed [29:0] c_q;
  logic [59:0] c2_q;
  logic [57:0] v_q, r_q, bit_q, rb;
  logic signed [31:0] x_q, y_q, xs, ys;
  logic signed [19:0] z_q, zc;
  logic [19:0] zr;
  logic [3:0]  i_q;
  logic        take, finish_now;
  logic signed [33:0] dot;

  // item may be taken in B_IDLE unless it closes an event while a result waits
  assign take = (state_q == B_IDLE) && !q_empty_i && !(rec_i.last && out_vld_q);
  assign finish_now = take && rec_i.last && (kept_d != 2'd2);
  assign rd_o = take;

  // top-two update
  always_comb begin
    l1_d = l1_q; l2_d = l2_q; d1_d = d1_q; d2_d = d2_q; kept_d = kept_q;
    if (rec_i.keep) begin
      priority if (kept_q == 2'd0) begin
        l1_d = rec_i.len; d1_d = rec_i.dir;
      end else if (rec_i.len > l1_q) begin
        l2_d = l1_q; d2_d = d1_q; l1_d = rec_i.len; d1_d = rec_i.dir;
      end else if (kept_q == 2'd1 || rec_i.len > l2_q) begin
        l2_d = rec_i.len; d2_d = rec_i.dir;
      end
      if (kept_q != 2'd2) kept_d = kept_q + 2'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:   if (take && rec_i.last && kept_d == 2'd2) state_d = B_DOT;
      B_DOT:    state_d = B_SUM;
      B_SUM:    state_d = B_SQ;
      B_SQ:     state_d = B_SUB;
      B_SUB:    state_d = B_SQRT;
      B_SQRT:   if (bit_q[0]) state_d = B_CORDIC;
      B_CORDIC: if (i_q == 4'(CORDIC_STEPS - 1)) state_d = B_DONE;
      B_DONE:   state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;

  assign rb  = r_q + bit_q;
  assign dot = 34'(p0_q) + 34'(p1_q) + 34'(p2_q);
  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign zc  = (z_q < 0) ? 20'sd0 : z_q;
  assign zr  = 20'((zc + 20'sd4) >>> 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      l1_q <= '0; l2_q <= '0; d1_q <= '0; d2_q <= '0; kept_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_i && out_vld_q) out_vld_q <= 1'b0;
      if (take) begin
        if (rec_i.last && kept_d != 2'd2) begin
          l1_q <= '0; l2_q <= '0; d1_q <= '0; d2_q <= '0; kept_q <= '0;
        end else begin
          l1_q <= l1_d; l2_q <= l2_d; d1_q <= d1_d; d2_q <= d2_d; kept_q <= kept_d;
        end
      end
      if (finish_now || state_q == B_DONE) out_vld_q <= 1'b1;
      if (state_q == B_DONE) begin
        l1_q <= '0; l2_q <= '0; d1_q <= '0; d2_q <= '0; kept_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_now) begin
      out_q.angle       <= '0;
      out_q.angle_valid <= 1'b0;
      out_q.kept_count  <= kept_d;
    end
    if (state_q == B_DONE) begin
      out_q.angle       <= (zr > PI_Q13) ? PI_Q13[14:0] : zr[14:0];
      out_q.angle_valid <= 1'b1;
      out_q.kept_count  <= kept_q;
    end
    unique case (state_q)
      B_DOT: begin
        p0_q <= $signed(d1_q[15:0])  * $signed(d2_q[15:0]);
        p1_q <= $signed(d1_q[31:16]) * $signed(d2_q[31:16]);
        p2_q <= $signed(d1_q[47:32]) * $signed(d2_q[47:32]);
      end
      B_SUM: begin
        priority if (dot > 34'sd268435456) c_q <= 30'sd268435456;
        else if (dot < -34'sd268435456) c_q <= -30'sd268435456;
        else c_q <= dot[29:0];
      end
      B_SQ: c2_q <= 60'(c_q * c_q);
      B_SUB: begin
        v_q   <= 58'(60'h100_0000_0000_0000 - c2_q);
        r_q   <= '0;
        bit_q <= 58'h100_0000_0000_0000;
      end
      B_SQRT: begin
        if (v_q >= rb) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        i_q   <= '0;
        if (bit_q[0]) begin
          // sqrt result is final after this step
          if (c_q < 0) begin
            x_q <= 32'((v_q >= rb) ? (r_q >> 1) + bit_q : r_q >> 1);
            y_q <= -32'(c_q);
            z_q <= HALF_PI_Q16;
          end else begin
            x_q <= 32'(c_q);
            y_q <= 32'((v_q >= rb) ? (r_q >> 1) + bit_q : r_q >> 1);
            z_q <= '0;
          end
        end
      end
      B_CORDIC: begin
        if (y_q > 0) begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q16(i_q);
        end else begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q16(i_q);
        end
        i_q <= i_q + 4'd1;
      end
      default: ;
    endcase
  end
endmodule

>>> tb/testbench.sv
// Testbench for vertex_track_pair_angle: streams track items through the
// push/full port, predicts each event's angle result and checks it on pop.
// Depends on vtpa_pkg and the vertex_track_pair_angle RTL.
`timescale 1ns / 1ps

module testbench;
  import vtpa_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  vtpa_in_t    in_item_i = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  vtpa_out_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_MAX_DISTANCE;
  logic [15:0] cfg_data_i = '0;

  vertex_track_pair_angle uut (
    .clk_i, .rst_ni, .push, .in_item_i, .full, .empty, .pop, .out_item_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of registers and event state
  logic [11:0]        p_max_dist;
  logic signed [15:0] p_vx, p_vy, p_vz;
  logic [15:0]        p_len1, p_len2;
  logic [47:0]        p_dir1, p_dir2;
  logic [1:0]         p_kept;

  vtpa_out_t angle_queue[$];
  int  n_items, n_results, n_valid, n_errors;
  int  cycles;
  bit  send_idle_on = 1'b1, pop_idle_on = 1'b1;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    vtpa_out_t want;
    if (rst_ni && pop && !empty) begin
      n_results <= n_results + 1;
      if (angle_queue.size() == 0) begin
        n_errors = n_errors + 1;
        if (n_errors <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        want = angle_queue.pop_front();
        if (want.angle_valid) n_valid <= n_valid + 1;
        if (out_item_o.angle !== want.angle || out_item_o.angle_valid !== want.angle_valid
            || out_item_o.kept_count !== want.kept_count) begin
          n_errors = n_errors + 1;
          if (n_errors <= 10)
            $display("mismatch: expected angle %0d valid %0b kept %0d, got %0d %0b %0d",
                     want.angle, want.angle_valid, want.kept_count, out_item_o.angle,
                     out_item_o.angle_valid, out_item_o.kept_count);
        end
      end
    end
    pop <= pop_idle_on ? ($urandom_range(99) >= 35) : 1'b1;
  end

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [14:0] pair_angle(logic [47:0] a, logic [47:0] b);
    logic signed [63:0] c, x, y, z, t, xs, ys;
    logic signed [63:0] one;
    one = 64'sd1 <<< 28;
    c = 0;
    z = 0;
    for (int k = 0; k < 3; k++)
      c += 64'(signed'(a[16*k +: 16])) * 64'(signed'(b[16*k +: 16]));
    if (c > one) c = one;
    if (c < -one) c = -one;
    x = c;
    y = int_sqrt(64'(one * one - c * c));
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'(HALF_PI_Q16);
    end
    for (int i = 0; i < 16; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += 64'(atan_q16(4'(i)));
      end else begin
        x -= ys; y += xs; z -= 64'(atan_q16(4'(i)));
      end
    end
    if (z < 0) z = 0;
    z = (z + 4) >>> 3;
    if (z > 25736) z = 25736;
    return 15'(z);
  endfunction

  function automatic bit near_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] z);
    logic signed [63:0] dx, dy, dz;
    dx = 64'(x) - 64'(p_vx);
    dy = 64'(y) - 64'(p_vy);
    dz = 64'(z) - 64'(p_vz);
    return (dx * dx + dy * dy + dz * dz) < 64'(p_max_dist) * 64'(p_max_dist);
  endfunction

  function automatic logic [47:0] flip_dir(logic [47:0] d);
    logic [47:0] r;
    for (int k = 0; k < 3; k++)
      r[16*k +: 16] = (d[16*k +: 16] == 16'h8000) ? 16'h7fff : 16'(-d[16*k +: 16]);
    return r;
  endfunction

  function automatic void add_kept(logic [15:0] len, logic [47:0] dir);
    if (p_kept == 0) begin
      p_len1 = len; p_dir1 = dir;
    end else if (len > p_len1) begin
      p_len2 = p_len1; p_dir2 = p_dir1;
      p_len1 = len; p_dir1 = dir;
    end else if (p_kept == 1 || len > p_len2) begin
      p_len2 = len; p_dir2 = dir;
    end
    if (p_kept < 2) p_kept++;
  endfunction

  function automatic void predict_track(vtpa_in_t it);
    vtpa_out_t r;
    if (it.has_track) begin
      if (near_vertex(it.start_x, it.start_y, it.start_z))
        add_kept(it.track_length, it.start_direction);
      else if (near_vertex(it.end_x, it.end_y, it.end_z))
        add_kept(it.track_length, flip_dir(it.end_direction));
    end
    if (!it.last_track) return;
    r.angle_valid = (p_kept >= 2);
    r.angle = r.angle_valid ? pair_angle(p_dir1, p_dir2) : 15'd0;
    r.kept_count = p_kept;
    angle_queue.push_back(r);
    p_len1 = 0; p_len2 = 0; p_dir1 = 0; p_dir2 = 0; p_kept = 0;
  endfunction

  // push stays as left here; the next call or wait_drained drives it again
  task automatic send_track(vtpa_in_t it);
    while (send_idle_on && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_track(it);
    n_items++;
  endtask

  // wait for every result, then give the back end time to go idle
  task automatic wait_drained();
    push <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_DISTANCE: p_max_dist = val[11:0];
      CFG_VERTEX_X:     p_vx = val;
      CFG_VERTEX_Y:     p_vy = val;
      CFG_VERTEX_Z:     p_vz = val;
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand_dir(bit unit_like);
    logic [47:0] d;
    d = 48'({$urandom, $urandom});
    if (unit_like)
      for (int k = 0; k < 3; k++)
        d[16*k +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    return d;
  endfunction

  // point near the vertex, or anywhere
  function automatic logic signed [15:0] rand_coord(logic signed [15:0] c, bit close);
    if (close) return 16'(32'(c) + $signed($urandom_range(200)) - 100);
    return 16'($urandom);
  endfunction

  function automatic vtpa_in_t rand_track(bit last);
    vtpa_in_t it;
    int mode;
    mode = $urandom_range(9);
    it.has_track = ($urandom_range(19) != 0);
    it.start_x = rand_coord(p_vx, mode < 4);
    it.start_y = rand_coord(p_vy, mode < 4);
    it.start_z = rand_coord(p_vz, mode < 4);
    it.end_x = rand_coord(p_vx, mode >= 4 && mode < 8);
    it.end_y = rand_coord(p_vy, mode >= 4 && mode < 8);
    it.end_z = rand_coord(p_vz, mode >= 4 && mode < 8);
    it.start_direction = rand_dir($urandom_range(3) != 0);
    it.end_direction = rand_dir($urandom_range(3) != 0);
    it.track_length = ($urandom_range(4) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
    it.last_track = last;
    return it;
  endfunction

  task automatic run_event(int n_tracks);
    for (int i = 0; i < n_tracks; i++) send_track(rand_track(i == n_tracks - 1));
  endtask

  task automatic test_directed();
    vtpa_in_t it;
    it = '0;
    // empty event close
    it.last_track = 1'b1;
    send_track(it);
    // two tracks at the vertex, opposite directions (angle pi)
    it = '0;
    it.has_track = 1'b1;
    it.track_length = 16'hffff;
    it.start_direction = {16'd0, 16'd0, 16'sd16384};
    send_track(it);
    it.start_direction = {16'd0, 16'd0, -16'sd16384};
    it.last_track = 1'b1;
    send_track(it);
    // perpendicular directions, equal length tie, then a shorter third track
    it.last_track = 1'b0;
    it.track_length = 16'd100;
    it.start_direction = {16'sd16384, 16'd0, 16'd0};
    send_track(it);
    it.start_direction = {16'd0, 16'sd16384, 16'd0};
    send_track(it);
    it.track_length = 16'd0;
    it.start_direction = 48'h8000_8000_8000;
    it.last_track = 1'b1;
    send_track(it);
    // start far, end near: negated end direction with saturating component
    it = '0;
    it.has_track = 1'b1;
    it.start_x = 16'sh7fff; it.start_y = 16'sh8000; it.start_z = 16'sh7fff;
    it.end_x = 16'sd159;
    it.end_direction = 48'h8000_7fff_8000;
    it.track_length = 16'd5;
    send_track(it);
    // exactly on the boundary: not kept
    it.end_x = 16'sd160;
    send_track(it);
    // unnormalized directions saturate the clamp
    it = '0;
    it.has_track = 1'b1;
    it.start_direction = 48'h7fff_7fff_7fff;
    it.track_length = 16'd7;
    send_track(it);
    it.last_track = 1'b1;
    it.has_track = 1'b0;
    send_track(it);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    logic [15:0] dists[4] = '{16'd0, 16'd4095, 16'd1, 16'd300};
    logic [15:0] verts[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'h1234};
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_MAX_DISTANCE, dists[s]);
      write_reg(CFG_VERTEX_X, verts[s]);
      write_reg(CFG_VERTEX_Y, verts[(s + 1) % 4]);
      write_reg(CFG_VERTEX_Z, verts[(s + 2) % 4]);
      for (int e = 0; e < 15; e++) run_event($urandom_range(1, 5));
      wait_drained();
    end
    write_reg(CFG_MAX_DISTANCE, 16'd160);
    write_reg(CFG_VERTEX_X, 16'd0);
    write_reg(CFG_VERTEX_Y, 16'd0);
    write_reg(CFG_VERTEX_Z, 16'd0);
  endtask

  task automatic test_random_stream();
    // a stretch with no idling on either side, then random idling
    send_idle_on = 1'b0;
    pop_idle_on = 1'b0;
    for (int e = 0; e < 40; e++) run_event($urandom_range(1, 4));
    send_idle_on = 1'b1;
    pop_idle_on = 1'b1;
    wait_drained();
    while (n_items < 1230) run_event($urandom_range(1, 6));
    wait_drained();
  endtask

  initial begin
    p_max_dist = MAX_DISTANCE_RST;
    p_vx = 0; p_vy = 0; p_vz = 0;
    p_len1 = 0; p_len2 = 0; p_dir1 = 0; p_dir2 = 0; p_kept = 0;
    n_items = 0; n_results = 0; n_valid = 0; n_errors = 0; cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random_stream();
    $display("covered %0d track items, %0d event results (%0d with a valid angle)",
             n_items, n_results, n_valid);
    $display("four register settings incl. extremes, idle and stall phases");
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/vtpa_pkg.sv
src/vtpa_fifo.sv
src/vtpa_front.sv
src/vtpa_back.sv
src/vertex_track_pair_angle.sv
tb/testbench.sv
